[rtl/m4te_pkg.sv]
package m4te_pkg;

    // geometry of the matrices
    localparam int DIM   = 4;
    localparam int IDX_W = $clog2(DIM);
    localparam int CNT_W = 2 * IDX_W;

    // fixed point format
    localparam int Q_W           = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * Q_W;
    localparam int SHIFT_W       = PROD_W - FRACTION_BITS;
    localparam int ACC_W         = SHIFT_W + IDX_W;

    // input item layout in tdata, lowest bit first
    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + IDX_W;
    localparam int VAL_LSB  = COL_LSB + IDX_W;
    localparam int VX_LSB   = VAL_LSB + Q_W;
    localparam int S_USED_W = VX_LSB + DIM * Q_W;
    localparam int S_DATA_W = ((S_USED_W + 7) / 8) * 8;
    localparam int S_USER_W = 3;

    // result item layout
    localparam int M_DATA_W = DIM * Q_W;
    localparam int M_USER_W = 1;

    // index of the last beat of one command
    localparam int LAST_TR_BEAT = DIM - 1;
    localparam int LAST_CP_BEAT = DIM * DIM - 1;

    // saturation limits
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [S_USER_W-1:0] {
        CMD_WR_CUR    = 3'd0,
        CMD_WR_OPD    = 3'd1,
        CMD_COMPOSE_R = 3'd2,
        CMD_COMPOSE_L = 3'd3,
        CMD_TRANSFORM = 3'd4
    } t_cmd;

    // control travelling with one multiply-accumulate beat
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_beat;

    // saturated dot product of one lane
    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] sum;
    } t_lane_res;

endpackage

[rtl/m4te_lane.sv]
module m4te_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  m4te_pkg::t_beat                   i_beat,
    input  logic signed [m4te_pkg::Q_W-1:0]   i_a,
    input  logic signed [m4te_pkg::Q_W-1:0]   i_b,
    output m4te_pkg::t_lane_res               o_res,
    output logic                              o_done
);

    logic signed [m4te_pkg::PROD_W-1:0]  r_prod;
    logic                                r_v1;
    logic                                r_first1;
    logic                                r_last1;
    logic signed [m4te_pkg::ACC_W-1:0]   r_acc;
    logic                                r_done;
    logic signed [m4te_pkg::SHIFT_W-1:0] w_shift;
    logic signed [m4te_pkg::ACC_W-1:0]   w_ext;
    logic [m4te_pkg::ACC_W-m4te_pkg::Q_W:0] w_hi;
    logic                                w_ovf;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_last1  <= 1'b0;
        end else begin
            r_v1     <= i_beat.valid;
            r_first1 <= i_beat.first;
            r_last1  <= i_beat.last;
        end
    end

    // arithmetic shift rounds towards minus infinity
    assign w_shift = r_prod[m4te_pkg::PROD_W-1:m4te_pkg::FRACTION_BITS];
    assign w_ext   = m4te_pkg::ACC_W'(w_shift);

    // accumulate stage, holds its sum while no beat arrives
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_acc <= r_first1 ? w_ext : r_acc + w_ext;
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v1 & r_last1;
        end
    end

    // saturate to the 32 bit range
    assign w_hi  = r_acc[m4te_pkg::ACC_W-1:m4te_pkg::Q_W-1];
    assign w_ovf = !((&w_hi) || !(|w_hi));

    always_comb begin
        o_res.ovf = w_ovf;
        if (w_ovf) begin
            o_res.sum = r_acc[m4te_pkg::ACC_W-1] ? m4te_pkg::Q_MIN : m4te_pkg::Q_MAX;
        end else begin
            o_res.sum = r_acc[m4te_pkg::Q_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

[rtl/m4te_merge.sv]
module m4te_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    output logic                            o_load_ready,
    input  m4te_pkg::t_lane_res             i_res [m4te_pkg::DIM],
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [m4te_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // overflow
    output logic [m4te_pkg::M_USER_W-1:0]   o_m_axis_tuser
);

    logic                          r_valid;
    logic [m4te_pkg::M_DATA_W-1:0] r_data;
    logic                          r_ovf;
    logic [m4te_pkg::M_DATA_W-1:0] w_data;
    logic                          w_ovf;

    // gather the lanes into one item
    always_comb begin
        w_ovf = 1'b0;
        for (int j = 0; j < m4te_pkg::DIM; j++) begin
            w_data[j*m4te_pkg::Q_W +: m4te_pkg::Q_W] = i_res[j].sum;
            w_ovf = w_ovf | i_res[j].ovf;
        end
    end

    assign o_load_ready = !r_valid || i_m_axis_tready;

    // output register
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ready) begin
            r_data <= w_data;
            r_ovf  <= w_ovf;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_ovf;

endmodule

[rtl/matrix4_transform_engine.sv]
// channel   direction  ports               contents
// s_axis    in         tdata, tuser        command and its operands
// m_axis    out        tdata, tuser        transformed vertex and overflow
//
// element writes complete on accept; a transform or compose finishes before the next
// item is taken; four lanes each take one product a cycle through a
// two-stage multiply-accumulate (4 or 16 beats)
// synchronous active-low reset clears the sequencer and the output register;
// matrix entries are undefined until written; a result held on m_axis stalls a
// following transform before its result is loaded; new items wait for idle
module matrix4_transform_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // row, col, element_value, vx, vy, vz, vw, zero padding
    input  logic [m4te_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // command
    input  logic [m4te_pkg::S_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [m4te_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // overflow
    output logic [m4te_pkg::M_USER_W-1:0]   o_m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    m4te_pkg::t_cmd                  r_mode, n_mode;
    logic [m4te_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_fin1, r_fin2;
    logic [m4te_pkg::IDX_W-1:0]      r_row1, r_row2;

    // matrices stored one column bank per lane: [col][row]
    logic [m4te_pkg::Q_W-1:0]        r_cur [m4te_pkg::DIM][m4te_pkg::DIM];
    logic [m4te_pkg::Q_W-1:0]        r_opd [m4te_pkg::DIM][m4te_pkg::DIM];
    logic [m4te_pkg::Q_W-1:0]        r_new [m4te_pkg::DIM][m4te_pkg::DIM];
    logic [m4te_pkg::Q_W-1:0]        r_vtx [m4te_pkg::DIM];

    m4te_pkg::t_cmd                  w_cmd;
    logic                            w_acc;
    logic [m4te_pkg::IDX_W-1:0]      w_row, w_col, w_i, w_k;
    logic [m4te_pkg::Q_W-1:0]        w_val;
    logic                            w_final;
    logic                            w_is_tr;
    logic                            w_load, w_load_ready, w_copy;
    m4te_pkg::t_beat                 w_beat;
    logic signed [m4te_pkg::Q_W-1:0] w_a [m4te_pkg::DIM];
    logic signed [m4te_pkg::Q_W-1:0] w_b;
    m4te_pkg::t_lane_res             w_res [m4te_pkg::DIM];
    logic [m4te_pkg::DIM-1:0]        w_done;

    // input item fields
    assign w_cmd   = m4te_pkg::t_cmd'(i_s_axis_tuser);
    assign w_row   = i_s_axis_tdata[m4te_pkg::ROW_LSB +: m4te_pkg::IDX_W];
    assign w_col   = i_s_axis_tdata[m4te_pkg::COL_LSB +: m4te_pkg::IDX_W];
    assign w_val   = i_s_axis_tdata[m4te_pkg::VAL_LSB +: m4te_pkg::Q_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_i     = r_cnt[m4te_pkg::CNT_W-1:m4te_pkg::IDX_W];
    assign w_k     = r_cnt[m4te_pkg::IDX_W-1:0];
    assign w_is_tr = (r_mode == m4te_pkg::CMD_TRANSFORM);
    assign w_final = w_is_tr ? (r_cnt == m4te_pkg::CNT_W'(m4te_pkg::LAST_TR_BEAT))
                             : (r_cnt == m4te_pkg::CNT_W'(m4te_pkg::LAST_CP_BEAT));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && (w_cmd == m4te_pkg::CMD_COMPOSE_R ||
                              w_cmd == m4te_pkg::CMD_COMPOSE_L ||
                              w_cmd == m4te_pkg::CMD_TRANSFORM)) begin
                    n_mode  = w_cmd;
                    n_cnt   = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_final) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_fin2) begin
                    n_state = (w_is_tr && w_load_ready) ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!w_is_tr || w_load_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= m4te_pkg::CMD_WR_CUR;
            r_cnt   <= '0;
            r_fin1  <= 1'b0;
            r_fin2  <= 1'b0;
            r_row1  <= '0;
            r_row2  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_fin1  <= (r_state == ST_RUN) && w_final;
            r_fin2  <= r_fin1;
            r_row1  <= w_i;
            r_row2  <= r_row1;
        end
    end

    // beat control shared by all lanes
    assign w_beat.valid = (r_state == ST_RUN);
    assign w_beat.first = (w_k == '0);
    assign w_beat.last  = (w_k == m4te_pkg::IDX_W'(m4te_pkg::DIM - 1));

    // operand selection: lane j owns column j, the other factor is broadcast
    always_comb begin
        for (int j = 0; j < m4te_pkg::DIM; j++) begin
            if (r_mode == m4te_pkg::CMD_COMPOSE_L) begin
                w_a[j] = r_opd[j][w_k];
            end else begin
                w_a[j] = r_cur[j][w_k];
            end
        end
        case (r_mode)
            m4te_pkg::CMD_TRANSFORM: w_b = r_vtx[w_k];
            m4te_pkg::CMD_COMPOSE_R: w_b = r_opd[w_k][w_i];
            m4te_pkg::CMD_COMPOSE_L: w_b = r_cur[w_k][w_i];
            default:                 w_b = '0;
        endcase
    end

    for (genvar j = 0; j < m4te_pkg::DIM; j++) begin : g_lane
        m4te_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat),
            .i_a     (w_a[j]),
            .i_b     (w_b),
            .o_res   (w_res[j]),
            .o_done  (w_done[j])
        );
    end

    assign w_load = ((r_state == ST_DRAIN && r_fin2) || r_state == ST_FINISH) &&
                    w_is_tr && w_load_ready;
    assign w_copy = (r_state == ST_FINISH) && !w_is_tr;

    m4te_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .o_load_ready    (w_load_ready),
        .i_res           (w_res),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // matrix storage, vertex latch and compose buffer
    always_ff @(posedge i_clk) begin
        if (w_acc && w_cmd == m4te_pkg::CMD_WR_CUR) begin
            r_cur[w_col][w_row] <= w_val;
        end
        if (w_acc && w_cmd == m4te_pkg::CMD_WR_OPD) begin
            r_opd[w_col][w_row] <= w_val;
        end
        if (w_acc && w_cmd == m4te_pkg::CMD_TRANSFORM) begin
            for (int k = 0; k < m4te_pkg::DIM; k++) begin
                r_vtx[k] <= i_s_axis_tdata[m4te_pkg::VX_LSB + k*m4te_pkg::Q_W +:
                                           m4te_pkg::Q_W];
            end
        end
        if (w_done[0] && !w_is_tr) begin
            for (int j = 0; j < m4te_pkg::DIM; j++) begin
                r_new[j][r_row2] <= w_res[j].sum;
            end
        end
        if (w_copy) begin
            r_cur <= r_new;
        end
    end

    // lanes run in lock step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done == '0 || w_done == '1)
        else $error("lanes out of step");

    // the last sum only appears while draining
    a_fin_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin2 |-> r_state == ST_DRAIN && w_done[0])
        else $error("final sum outside drain");

    // a new command starts with an empty pipeline
    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == '0) |-> !r_fin1 && !r_fin2 && w_done == '0)
        else $error("pipeline busy at command start");

    // a transform item starts the sequencer
    a_tr_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == m4te_pkg::CMD_TRANSFORM) |=> r_state == ST_RUN && w_is_tr)
        else $error("transform not started");

endmodule

[bench/matrix4_transform_engine_tb.sv]
module matrix4_transform_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // command codes the block ignores
    localparam logic [m4te_pkg::S_USER_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [m4te_pkg::S_USER_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [m4te_pkg::S_USER_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [m4te_pkg::Q_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [m4te_pkg::Q_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [m4te_pkg::Q_W-1:0] Q_MAX     = m4te_pkg::Q_MAX;
    localparam logic [m4te_pkg::Q_W-1:0] Q_MIN     = m4te_pkg::Q_MIN;
    localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SUM_MIN = 64'shFFFF_FFFF_8000_0000;

    localparam int RESET_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 630;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;

    // vertex components, index k is v[k]
    typedef logic [m4te_pkg::DIM-1:0][m4te_pkg::Q_W-1:0] t_vec;

    typedef struct packed {
        t_vec comp;
        logic ovf;
    } t_vertex_res;

    typedef struct packed {
        logic [m4te_pkg::S_USER_W-1:0] cmd;
        logic [m4te_pkg::IDX_W-1:0]    row;
        logic [m4te_pkg::IDX_W-1:0]    col;
        logic [m4te_pkg::Q_W-1:0]      val;
        t_vec                          vtx;
        logic                          fixed;    // res below is typed in, not predicted
        t_vertex_res                   res;
    } t_cmd_item;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // row, col, element_value, vx, vy, vz, vw, zero padding
    logic [m4te_pkg::S_DATA_W-1:0]   i_s_axis_tdata = '0;
    // command
    logic [m4te_pkg::S_USER_W-1:0]   i_s_axis_tuser = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // out_x, out_y, out_z, out_w
    logic [m4te_pkg::M_DATA_W-1:0]   o_m_axis_tdata;
    // overflow
    logic [m4te_pkg::M_USER_W-1:0]   o_m_axis_tuser;

    // predictor state
    logic signed [m4te_pkg::Q_W-1:0] cur_m [m4te_pkg::DIM][m4te_pkg::DIM];
    logic signed [m4te_pkg::Q_W-1:0] opd_m [m4te_pkg::DIM][m4te_pkg::DIM];
    t_vertex_res                     pending_vertices [$];

    int    errors = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    quiet_cycles = 0;
    string comp_name [m4te_pkg::DIM] = '{"out_x", "out_y", "out_z", "out_w"};

    matrix4_transform_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // q product, arithmetic shift so it rounds toward minus infinity
    function automatic longint q_product(logic signed [m4te_pkg::Q_W-1:0] a,
                                         logic signed [m4te_pkg::Q_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> m4te_pkg::FRACTION_BITS;
    endfunction

    function automatic m4te_pkg::t_lane_res saturate(longint s);
        m4te_pkg::t_lane_res r;
        r.ovf = 1'b0;
        r.sum = s[m4te_pkg::Q_W-1:0];
        if (s > SUM_MAX) begin
            r.ovf = 1'b1;
            r.sum = Q_MAX;
        end else if (s < SUM_MIN) begin
            r.ovf = 1'b1;
            r.sum = Q_MIN;
        end
        return r;
    endfunction

    // update the matrices and queue the vertex expected from one item
    function automatic void apply_command(t_cmd_item it);
        logic signed [m4te_pkg::Q_W-1:0] nxt [m4te_pkg::DIM][m4te_pkg::DIM];
        longint                          acc;
        m4te_pkg::t_lane_res             lane;
        t_vertex_res                     res;
        case (it.cmd)
            m4te_pkg::CMD_WR_CUR: cur_m[it.row][it.col] = it.val;
            m4te_pkg::CMD_WR_OPD: opd_m[it.row][it.col] = it.val;
            m4te_pkg::CMD_COMPOSE_R, m4te_pkg::CMD_COMPOSE_L: begin
                for (int i = 0; i < m4te_pkg::DIM; i++) begin
                    for (int j = 0; j < m4te_pkg::DIM; j++) begin
                        acc = 0;
                        for (int k = 0; k < m4te_pkg::DIM; k++) begin
                            if (it.cmd == m4te_pkg::CMD_COMPOSE_R)
                                acc += q_product(cur_m[k][j], opd_m[i][k]);
                            else
                                acc += q_product(opd_m[k][j], cur_m[i][k]);
                        end
                        lane = saturate(acc);
                        nxt[i][j] = lane.sum;
                    end
                end
                cur_m = nxt;
            end
            m4te_pkg::CMD_TRANSFORM: begin
                res.ovf = 1'b0;
                for (int j = 0; j < m4te_pkg::DIM; j++) begin
                    acc = 0;
                    for (int k = 0; k < m4te_pkg::DIM; k++)
                        acc += q_product(cur_m[k][j], it.vtx[k]);
                    lane = saturate(acc);
                    res.comp[j] = lane.sum;
                    res.ovf |= lane.ovf;
                end
                pending_vertices.push_back(it.fixed ? it.res : res);
            end
            default: ;
        endcase
    endfunction

    // q values weighted toward small magnitudes and unity, with extremes and full-range words
    function automatic logic [m4te_pkg::Q_W-1:0] rand_q();
        logic [31:0] r;
        int unsigned pick;
        r = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return {{12{r[19]}}, r[19:0]};
        else if (pick < 15)
            return (r[31] ? -Q_ONE : Q_ONE) + {{20{r[11]}}, r[11:0]};
        else if (pick < 17) begin
            case (r[2:0])
                3'd0: return Q_MAX;
                3'd1: return Q_MIN;
                3'd2: return Q_NEG_LSB;
                3'd3: return Q_ONE;
                default: return '0;
            endcase
        end
        return r;
    endfunction

    function automatic t_vec vtx4(logic [m4te_pkg::Q_W-1:0] x, logic [m4te_pkg::Q_W-1:0] y,
                                  logic [m4te_pkg::Q_W-1:0] z, logic [m4te_pkg::Q_W-1:0] w);
        t_vec v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    function automatic t_cmd_item make_item(logic [m4te_pkg::S_USER_W-1:0] cmd,
                                            logic [m4te_pkg::IDX_W-1:0] row,
                                            logic [m4te_pkg::IDX_W-1:0] col,
                                            logic [m4te_pkg::Q_W-1:0] val,
                                            t_vec vtx, logic fixed, t_vec out, logic ovf);
        t_cmd_item it;
        it.cmd = cmd;
        it.row = row;
        it.col = col;
        it.val = val;
        it.vtx = vtx;
        it.fixed = fixed;
        it.res.comp = out;
        it.res.ovf = ovf;
        return it;
    endfunction

    // present one item, with random gaps before it, and wait for its accept
    task automatic send_item(t_cmd_item it);
        logic [m4te_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[m4te_pkg::ROW_LSB +: m4te_pkg::IDX_W] = it.row;
        d[m4te_pkg::COL_LSB +: m4te_pkg::IDX_W] = it.col;
        d[m4te_pkg::VAL_LSB +: m4te_pkg::Q_W] = it.val;
        for (int k = 0; k < m4te_pkg::DIM; k++)
            d[m4te_pkg::VX_LSB + k*m4te_pkg::Q_W +: m4te_pkg::Q_W] = it.vtx[k];
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        i_s_axis_tuser <= it.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        apply_command(it);
    endtask

    // sender holds off until every queued vertex has come back
    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_vertices.size() != 0);
    endtask

    // result side: compare each accepted vertex, then drive a random ready
    always @(posedge i_clk) begin : result_check
        t_vertex_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex result with no transform outstanding");
                errors++;
            end else begin
                want = pending_vertices.pop_front();
                for (int k = 0; k < m4te_pkg::DIM; k++) begin
                    if (o_m_axis_tdata[k*m4te_pkg::Q_W +: m4te_pkg::Q_W] !== want.comp[k]) begin
                        $error("%s: expected %0d, got %0d", comp_name[k],
                               $signed(want.comp[k]),
                               $signed(o_m_axis_tdata[k*m4te_pkg::Q_W +: m4te_pkg::Q_W]));
                        errors++;
                    end
                end
                if (o_m_axis_tuser[0] !== want.ovf) begin
                    $error("overflow: expected %0d, got %0d", want.ovf, o_m_axis_tuser[0]);
                    errors++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog on cycles in which no item moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd_item directed_items [$];
        t_cmd_item it;
        int        sent;
        int        pick;

        foreach (cur_m[i, j]) begin
            cur_m[i][j] = '0;
            opd_m[i][j] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 29;
        rx_idle_pct = 67;

        // load both matrices before anything reads them: identity and a scale with one shear term
        for (int i = 0; i < m4te_pkg::DIM; i++) begin
            for (int j = 0; j < m4te_pkg::DIM; j++) begin
                send_item(make_item(m4te_pkg::CMD_WR_CUR, m4te_pkg::IDX_W'(i),
                                    m4te_pkg::IDX_W'(j), (i == j) ? Q_ONE : '0,
                                    '0, 1'b0, '0, 1'b0));
                send_item(make_item(m4te_pkg::CMD_WR_OPD, m4te_pkg::IDX_W'(i),
                                    m4te_pkg::IDX_W'(j),
                                    (i == j) ? 2 * Q_ONE : ((i == 0 && j == 1) ? Q_ONE / 2 : '0),
                                    '0, 1'b0, '0, 1'b0));
            end
        end

        // identity passes the vertex through unchanged
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_ONE, 32'hFFFE_0000, 32'h0003_8000, '0), 1'b1,
            vtx4(Q_ONE, 32'hFFFE_0000, 32'h0003_8000, '0), 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1, vtx4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1, vtx4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0));
        // write fields set but ignored by a transform
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd3, 2'd3, Q_MIN,
            vtx4(Q_NEG_LSB, Q_NEG_LSB, '0, Q_NEG_LSB), 1'b1,
            vtx4(Q_NEG_LSB, Q_NEG_LSB, '0, Q_NEG_LSB), 1'b0));
        // saturation of a vertex component, both signs
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_CUR, 2'd0, 2'd0, Q_MAX,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_CUR, 2'd1, 2'd0, Q_MAX,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_MAX, Q_MAX, '0, '0), 1'b1, vtx4(Q_MAX, Q_MAX, '0, '0), 1'b1));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_MIN, Q_MIN, '0, '0), 1'b1, vtx4(Q_MIN, Q_MIN, '0, '0), 1'b1));
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_CUR, 2'd0, 2'd0, Q_MIN,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_MIN, '0, '0, '0), 1'b1, vtx4(Q_MAX, '0, '0, '0), 1'b1));
        // smallest negative entry: products round down to minus one lsb
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_CUR, 2'd3, 2'd3, Q_NEG_LSB,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_CUR, 2'd0, 2'd0, Q_ONE,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4('0, '0, '0, Q_ONE), 1'b1, vtx4('0, '0, '0, Q_NEG_LSB), 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4('0, '0, '0, 32'd1), 1'b1, vtx4('0, '0, '0, Q_NEG_LSB), 1'b0));
        // operand extremes, so both composes saturate some entries
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_OPD, 2'd0, 2'd1, Q_MAX,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_WR_OPD, 2'd3, 2'd3, Q_MIN,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_COMPOSE_R, 2'd2, 2'd1, Q_MAX,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_COMPOSE_L, 2'd0, 2'd0, '0,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(32'h0002_0000, 32'hFFFF_8000, Q_MAX, Q_MIN), 1'b0, '0, 1'b0));
        // unused commands leave both matrices alone
        directed_items.push_back(make_item(CMD_SPARE_5, 2'd0, 2'd0, Q_MAX,
            vtx4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(CMD_SPARE_6, 2'd3, 2'd3, Q_MIN,
            vtx4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(CMD_SPARE_7, 2'd1, 2'd2, Q_NEG_LSB,
            '0, 1'b0, '0, 1'b0));
        directed_items.push_back(make_item(m4te_pkg::CMD_TRANSFORM, 2'd0, 2'd0, '0,
            vtx4(32'h0000_8000, Q_ONE, 32'hFFFF_0000, Q_ONE), 1'b0, '0, 1'b0));

        foreach (directed_items[n])
            send_item(directed_items[n]);

        // random part in three idling phases, each after a full drain
        for (int ph = 0; ph < 3; ph++) begin
            hold_until_drained();
            case (ph)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 67;
                end
                1: begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    // reload a whole matrix with random values
                    for (int i = 0; i < m4te_pkg::DIM; i++) begin
                        for (int j = 0; j < m4te_pkg::DIM; j++) begin
                            send_item(make_item((pick < 2) ? m4te_pkg::CMD_WR_CUR
                                                           : m4te_pkg::CMD_WR_OPD,
                                                m4te_pkg::IDX_W'(i), m4te_pkg::IDX_W'(j),
                                                rand_q(), '0, 1'b0, '0, 1'b0));
                        end
                    end
                    sent += m4te_pkg::DIM * m4te_pkg::DIM;
                end else begin
                    it = make_item(m4te_pkg::CMD_WR_CUR,
                                   m4te_pkg::IDX_W'($urandom_range(0, m4te_pkg::DIM-1)),
                                   m4te_pkg::IDX_W'($urandom_range(0, m4te_pkg::DIM-1)),
                                   rand_q(),
                                   vtx4(rand_q(), rand_q(), rand_q(), rand_q()),
                                   1'b0, '0, 1'b0);
                    if (pick < 30)
                        it.cmd = m4te_pkg::CMD_WR_CUR;
                    else if (pick < 52)
                        it.cmd = m4te_pkg::CMD_WR_OPD;
                    else if (pick < 58)
                        it.cmd = m4te_pkg::CMD_COMPOSE_R;
                    else if (pick < 64)
                        it.cmd = m4te_pkg::CMD_COMPOSE_L;
                    else if (pick < 97)
                        it.cmd = m4te_pkg::CMD_TRANSFORM;
                    else
                        it.cmd = m4te_pkg::S_USER_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
                    send_item(it);
                    sent++;
                end
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
